[design/sgi_pkg.sv]
// Shared types and constants for the segment intersection pipeline.
// No dependencies; every other design file refers to this package by scope.
package sgi_pkg;

    localparam int NUM_W     = 50;   // |pp| and |qq|
    localparam int DEN_W     = 51;   // |pp| + |qq|
    localparam int REM_W     = 52;   // divider partial remainder
    localparam int Q_W       = 31;   // crossing fraction, Q1.30 in [0, 1]
    localparam int DIV_STEPS = 31;   // one quotient bit per stage

    localparam logic [61:0]        RND_30   = 62'h0000_0000_2000_0000;
    localparam logic signed [49:0] RND_14   = 50'sd8192;
    localparam logic signed [35:0] SAT_MAX  = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN  = -36'sd2147483648;

    typedef struct packed {
        logic signed [31:0] seg1_start_x;
        logic signed [31:0] seg1_start_y;
        logic signed [15:0] seg1_dir_x;
        logic signed [15:0] seg1_dir_y;
        logic        [30:0] seg1_length;
        logic signed [31:0] seg2_start_x;
        logic signed [31:0] seg2_start_y;
        logic signed [15:0] seg2_dir_x;
        logic signed [15:0] seg2_dir_y;
        logic        [30:0] seg2_length;
    } item_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] cross_x;
        logic signed [31:0] cross_y;
    } result_t;

    // Context that rides alongside the arithmetic through every stage.
    typedef struct packed {
        logic  valid;
        logic  no_hit;
        item_t item;
    } ctx_t;

endpackage

[design/sgi_front.sv]
// Front stages: side distances pp and qq, sign tests, divider operands.
// Depends on sgi_pkg.
module sgi_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  sgi_pkg::item_t                item,
    output sgi_pkg::ctx_t                 ctx,
    output logic [sgi_pkg::NUM_W-1:0]     num,
    output logic [sgi_pkg::DEN_W-1:0]     den
);

    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    sgi_pkg::item_t       i1_reg, i2_reg, i3_reg, i4_reg, i5_reg;
    logic signed [48:0]   ma_reg, mb_reg;
    logic signed [31:0]   mc_reg, md_reg;
    logic signed [49:0]   pp2_reg, pp3_reg, pp4_reg;
    logic signed [32:0]   c2_reg;
    logic signed [64:0]   lc3_reg;
    logic signed [50:0]   qq4_reg;
    logic                 nohit5_reg;
    logic [sgi_pkg::NUM_W-1:0] num5_reg;
    logic [sgi_pkg::DEN_W-1:0] den5_reg;

    logic signed [32:0]   dx, dy;
    logic signed [50:0]   pp_ext, ap_s, aq_s;
    logic                 nohit_next;

    assign dx = {item.seg2_start_x[31], item.seg2_start_x}
              - {item.seg1_start_x[31], item.seg1_start_x};
    assign dy = {item.seg2_start_y[31], item.seg2_start_y}
              - {item.seg1_start_y[31], item.seg1_start_y};

    assign pp_ext = 51'(pp4_reg);
    assign ap_s   = pp_ext[50]  ? -pp_ext  : pp_ext;
    assign aq_s   = qq4_reg[50] ? -qq4_reg : qq4_reg;
    // same strict sign, or both zero (collinear)
    assign nohit_next = (pp_ext > 0 && qq4_reg > 0) || (pp_ext < 0 && qq4_reg < 0)
                     || (pp_ext == 0 && qq4_reg == 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        i1_reg  <= item;
        ma_reg  <= dy * item.seg1_dir_x;
        mb_reg  <= dx * item.seg1_dir_y;
        mc_reg  <= item.seg2_dir_y * item.seg1_dir_x;
        md_reg  <= item.seg2_dir_x * item.seg1_dir_y;

        i2_reg  <= i1_reg;
        pp2_reg <= 50'(ma_reg) - 50'(mb_reg);
        c2_reg  <= 33'(mc_reg) - 33'(md_reg);

        i3_reg  <= i2_reg;
        pp3_reg <= pp2_reg;
        lc3_reg <= $signed({1'b0, i2_reg.seg2_length}) * c2_reg;

        i4_reg  <= i3_reg;
        pp4_reg <= pp3_reg;
        qq4_reg <= 51'(pp3_reg) + 51'(lc3_reg >>> 14);

        i5_reg     <= i4_reg;
        nohit5_reg <= nohit_next;
        num5_reg   <= ap_s[sgi_pkg::NUM_W-1:0];
        den5_reg   <= 51'(ap_s) + 51'(aq_s);
    end

    assign ctx.valid  = v5_reg;
    assign ctx.no_hit = nohit5_reg;
    assign ctx.item   = i5_reg;
    assign num        = num5_reg;
    assign den        = den5_reg;

endmodule

[design/sgi_divider.sv]
// Restoring fraction divider, one quotient bit per register stage.
// Depends on sgi_pkg.
module sgi_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sgi_pkg::ctx_t                 ctx_in,
    input  logic [sgi_pkg::NUM_W-1:0]     num,
    input  logic [sgi_pkg::DEN_W-1:0]     den,
    output sgi_pkg::ctx_t                 ctx_out,
    output logic [sgi_pkg::Q_W-1:0]       frac
);

    localparam int N = sgi_pkg::DIV_STEPS;

    logic                        v_reg   [N+1];
    sgi_pkg::item_t              it_reg  [N+1];
    logic                        nh_reg  [N+1];
    logic [sgi_pkg::REM_W-1:0]   rem_reg [N+1];
    logic [sgi_pkg::DEN_W-1:0]   den_reg [N+1];
    logic [sgi_pkg::Q_W-1:0]     q_reg   [N+1];

    logic [N-1:0]                ge;
    logic [sgi_pkg::REM_W-1:0]   rem_sub [N];

    // trial subtract for each stage
    for (genvar s = 0; s < N; s++)
    begin : g_step
        logic [sgi_pkg::REM_W-1:0] den_ext;

        assign den_ext    = sgi_pkg::REM_W'(den_reg[s]);
        assign ge[s]      = rem_reg[s] >= den_ext;
        assign rem_sub[s] = ge[s] ? rem_reg[s] - den_ext : rem_reg[s];
    end

    // stage 0 is the operand register; advance the valid bits every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= ctx_in.valid;
            for (int i = 0; i < N; i++)
                v_reg[i+1] <= v_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg[0]  <= ctx_in.item;
        nh_reg[0]  <= ctx_in.no_hit;
        rem_reg[0] <= sgi_pkg::REM_W'(num);
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        for (int i = 0; i < N; i++)
        begin
            it_reg[i+1]  <= it_reg[i];
            nh_reg[i+1]  <= nh_reg[i];
            den_reg[i+1] <= den_reg[i];
            rem_reg[i+1] <= {rem_sub[i][sgi_pkg::REM_W-2:0], 1'b0};
            q_reg[i+1]   <= {q_reg[i][sgi_pkg::Q_W-2:0], ge[i]};
        end
    end

    assign ctx_out.valid  = v_reg[N];
    assign ctx_out.no_hit = nh_reg[N];
    assign ctx_out.item   = it_reg[N];
    assign frac           = q_reg[N];

endmodule

[design/sgi_back.sv]
// Back stages: travel along segment 2, crossing point, extent test, saturation.
// Depends on sgi_pkg.
module sgi_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sgi_pkg::ctx_t             ctx,
    input  logic [sgi_pkg::Q_W-1:0]   frac,
    output logic                      done,
    output sgi_pkg::result_t          result
);

    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    sgi_pkg::item_t       i1_reg, i2_reg, i3_reg, i4_reg, i5_reg;
    logic                 n1_reg, n2_reg, n3_reg, n4_reg, n5_reg;
    logic [61:0]          lk_reg;
    logic [32:0]          t_reg;
    logic signed [49:0]   mx_reg, my_reg;
    logic signed [35:0]   px_reg, py_reg, px5_reg, py5_reg;
    logic signed [52:0]   hx_reg, hy_reg;
    sgi_pkg::result_t     res_reg;

    logic signed [49:0]   sx, sy;
    logic signed [36:0]   ex, ey;
    logic signed [53:0]   h, lim;
    logic                 hit;

    assign sx = (50'(i3_reg.seg2_start_x) <<< 14) + mx_reg + sgi_pkg::RND_14;
    assign sy = (50'(i3_reg.seg2_start_y) <<< 14) + my_reg + sgi_pkg::RND_14;
    assign ex = 37'(px_reg) - 37'(i4_reg.seg1_start_x);
    assign ey = 37'(py_reg) - 37'(i4_reg.seg1_start_y);
    assign h   = 54'(hx_reg) + 54'(hy_reg);
    assign lim = $signed({9'b0, i5_reg.seg1_length, 14'b0});
    assign hit = !n5_reg && (h >= 0) && (h <= lim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctx.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        i1_reg <= ctx.item;
        n1_reg <= ctx.no_hit;
        lk_reg <= 62'(ctx.item.seg2_length) * 62'(frac);

        i2_reg <= i1_reg;
        n2_reg <= n1_reg;
        t_reg  <= 33'((lk_reg + sgi_pkg::RND_30) >> 30);

        i3_reg <= i2_reg;
        n3_reg <= n2_reg;
        mx_reg <= i2_reg.seg2_dir_x * $signed({1'b0, t_reg});
        my_reg <= i2_reg.seg2_dir_y * $signed({1'b0, t_reg});

        i4_reg <= i3_reg;
        n4_reg <= n3_reg;
        px_reg <= 36'(sx >>> 14);
        py_reg <= 36'(sy >>> 14);

        i5_reg  <= i4_reg;
        n5_reg  <= n4_reg;
        px5_reg <= px_reg;
        py5_reg <= py_reg;
        hx_reg  <= ex * i4_reg.seg1_dir_x;
        hy_reg  <= ey * i4_reg.seg1_dir_y;

        res_reg.hit <= hit;
        if (!hit)
            res_reg.cross_x <= '0;
        else if (px5_reg > sgi_pkg::SAT_MAX)
            res_reg.cross_x <= 32'sh7FFF_FFFF;
        else if (px5_reg < sgi_pkg::SAT_MIN)
            res_reg.cross_x <= 32'sh8000_0000;
        else
            res_reg.cross_x <= px5_reg[31:0];
        if (!hit)
            res_reg.cross_y <= '0;
        else if (py5_reg > sgi_pkg::SAT_MAX)
            res_reg.cross_y <= 32'sh7FFF_FFFF;
        else if (py5_reg < sgi_pkg::SAT_MIN)
            res_reg.cross_y <= 32'sh8000_0000;
        else
            res_reg.cross_y <= py5_reg[31:0];
    end

    assign done   = v6_reg;
    assign result = res_reg;

endmodule

[design/segment_intersection_unit.sv]
// Top level of the 2-D segment intersection pipeline.
// Depends on sgi_pkg, sgi_front, sgi_divider and sgi_back.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------
//  segments  | start, busy        | item   (sgi_pkg::item_t)
//  result    | done (strobe)      | result (sgi_pkg::result_t)
//
// One transaction enters every cycle; busy is always low.
// The path from start to done runs through 5 front stages, the operand
// register plus 31 single-bit divider stages, and 6 back stages.
// Reset clears only the valid bits that travel with each transaction.
// The receiver cannot stall, so the pipeline never holds.
module segment_intersection_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sgi_pkg::item_t    item,
    output logic              done,
    output sgi_pkg::result_t  result
);

    sgi_pkg::ctx_t                 f_ctx, d_ctx;
    logic [sgi_pkg::NUM_W-1:0]     f_num;
    logic [sgi_pkg::DEN_W-1:0]     f_den;
    logic [sgi_pkg::Q_W-1:0]       d_frac;

    // never stall the input: every stage advances every cycle
    assign busy = 1'b0;

    // side distances and the no-hit test
    sgi_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start & ~busy),
        .item  (item),
        .ctx   (f_ctx),
        .num   (f_num),
        .den   (f_den)
    );

    // crossing fraction |pp| / (|pp| + |qq|)
    sgi_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctx_in  (f_ctx),
        .num     (f_num),
        .den     (f_den),
        .ctx_out (d_ctx),
        .frac    (d_frac)
    );

    // crossing point, extent check and output register
    sgi_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctx    (d_ctx),
        .frac   (d_frac),
        .done   (done),
        .result (result)
    );

endmodule

[tb/tb.sv]
// Testbench for segment_intersection_unit: drives segment pairs and checks
// hit flag and crossing point against an in-bench fixed-point predictor.
// Depends on sgi_pkg and the segment_intersection_unit RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgi_pkg::*;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    item_t   item = '0;
    logic    done;
    result_t result;

    result_t expected_q[$];
    int      mismatch_cnt = 0;
    int      idle_cycles = 0;
    bit      gaps_on = 1'b1;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;

    segment_intersection_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #6 clk = ~clk;

    // floor(v / 2^s) for signed values
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Compute the crossing of the second segment with the first.
    function automatic result_t predict_crossing(item_t s);
        longint ax1, ay1, ux1, uy1, l1, ax2, ay2, ux2, uy2, l2;
        longint pp, qq, c, ap, aq, k, t, px, py, h, rem, den;
        result_t r;
        r = '0;
        ax1 = s.seg1_start_x; ay1 = s.seg1_start_y;
        ux1 = s.seg1_dir_x;   uy1 = s.seg1_dir_y;
        l1  = longint'({1'b0, s.seg1_length});
        ax2 = s.seg2_start_x; ay2 = s.seg2_start_y;
        ux2 = s.seg2_dir_x;   uy2 = s.seg2_dir_y;
        l2  = longint'({1'b0, s.seg2_length});
        pp = (ay2 - ay1) * ux1 - (ax2 - ax1) * uy1;
        c  = uy2 * ux1 - ux2 * uy1;
        qq = pp + floor_shr(l2 * c, 14);
        if ((pp > 0 && qq > 0) || (pp < 0 && qq < 0))
            return r;
        if (pp == 0 && qq == 0)
            return r;
        ap = (pp < 0) ? -pp : pp;
        aq = (qq < 0) ? -qq : qq;
        den = ap + aq;
        // restoring division, one quotient bit per step
        k = 0;
        rem = ap;
        for (int i = 0; i < 31; i++)
        begin
            k = k << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                k = k | 1;
            end
            rem = rem << 1;
        end
        t  = floor_shr(l2 * k + (64'sd1 << 29), 30);
        px = floor_shr(ax2 * 16384 + ux2 * t + 8192, 14);
        py = floor_shr(ay2 * 16384 + uy2 * t + 8192, 14);
        h  = (px - ax1) * ux1 + (py - ay1) * uy1;
        if (h >= 0 && h <= l1 * 16384)
        begin
            r.hit     = 1'b1;
            r.cross_x = 32'(clamp32(px));
            r.cross_y = 32'(clamp32(py));
        end
        return r;
    endfunction

    // Send one transaction; hold start until the edge that accepts it.
    task automatic send_segments(item_t s);
        while (gaps_on && $urandom_range(99) < 31)
        begin
            if (start)
                start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_q.push_back(predict_crossing(s));
    endtask

    task automatic release_start();
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_dir();
        case ($urandom_range(9))
            0: return 16'(-32768);
            1: return 16'(16384);
            2: return 16'(-16384);
            3: return 16'($urandom);
            default: return 16'($urandom_range(32768) - 16384);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($urandom_range(2000000) - 1000000);
        endcase
    endfunction

    function automatic logic [30:0] rand_len();
        case ($urandom_range(5))
            0: return 31'h7FFF_FFFF;
            1: return 31'($urandom);
            default: return 31'($urandom_range(4000000));
        endcase
    endfunction

    // Build a pair that crosses: seg2 passes through a point on seg1.
    function automatic item_t crossing_pair();
        item_t s;
        int a1, a2;
        longint along, back, px, py;
        logic signed [15:0] d1x, d1y, d2x, d2y;
        a1 = $urandom_range(359);
        a2 = $urandom_range(359);
        d1x = 16'($rtoi(16384.0 * $cos(a1 * 3.14159265 / 180.0)));
        d1y = 16'($rtoi(16384.0 * $sin(a1 * 3.14159265 / 180.0)));
        d2x = 16'($rtoi(16384.0 * $cos(a2 * 3.14159265 / 180.0)));
        d2y = 16'($rtoi(16384.0 * $sin(a2 * 3.14159265 / 180.0)));
        s.seg1_start_x = 32'($urandom_range(2000000) - 1000000);
        s.seg1_start_y = 32'($urandom_range(2000000) - 1000000);
        s.seg1_dir_x = d1x;
        s.seg1_dir_y = d1y;
        s.seg1_length = 31'($urandom_range(2000000) + 1);
        along = $urandom_range(s.seg1_length);
        back = $urandom_range(2000000);
        px = s.seg1_start_x + ((along * d1x) >>> 14);
        py = s.seg1_start_y + ((along * d1y) >>> 14);
        s.seg2_start_x = 32'(px - ((back * d2x) >>> 14));
        s.seg2_start_y = 32'(py - ((back * d2y) >>> 14));
        s.seg2_dir_x = d2x;
        s.seg2_dir_y = d2y;
        s.seg2_length = 31'(back + $urandom_range(2000000));
        return s;
    endfunction

    function automatic item_t noise_pair();
        item_t s;
        s.seg1_start_x = rand_coord();
        s.seg1_start_y = rand_coord();
        s.seg1_dir_x = rand_dir();
        s.seg1_dir_y = rand_dir();
        s.seg1_length = rand_len();
        s.seg2_start_x = rand_coord();
        s.seg2_start_y = rand_coord();
        s.seg2_dir_x = rand_dir();
        s.seg2_dir_y = rand_dir();
        s.seg2_length = rand_len();
        return s;
    endfunction

    // Directed corners: crossing, parallel, collinear, touching ends,
    // saturated point, field extremes and ten noise pairs.
    task automatic test_directed();
        item_t s;
        // plain crossing of the axes
        s = '0;
        s.seg1_start_x = -32'sd65536; s.seg1_dir_x = 16'sd16384;
        s.seg1_length = 31'd131072;
        s.seg2_start_y = -32'sd65536; s.seg2_dir_y = 16'sd16384;
        s.seg2_length = 31'd131072;
        send_segments(s);
        // parallel, offset: same sign
        s.seg2_start_x = 32'sd0; s.seg2_start_y = 32'sd65536;
        s.seg2_dir_x = 16'sd16384; s.seg2_dir_y = 16'sd0;
        send_segments(s);
        // collinear
        s.seg2_start_y = 32'sd0;
        send_segments(s);
        // start of seg2 touching seg1
        s.seg2_dir_x = 16'sd0; s.seg2_dir_y = 16'sd16384;
        send_segments(s);
        // end of seg2 touching seg1
        s.seg2_start_y = -32'sd65536; s.seg2_length = 31'd65536;
        send_segments(s);
        // crossing beyond seg1 extent
        s.seg2_start_x = 32'sd300000;
        send_segments(s);
        // point wide enough to saturate
        s = '0;
        s.seg1_start_x = 32'h7FFF_0000; s.seg1_dir_x = 16'sd16384;
        s.seg1_length = 31'h7FFF_FFFF;
        s.seg2_start_x = 32'h7FFF_FFFF; s.seg2_start_y = -32'sd65536;
        s.seg2_dir_x = 16'sd16384; s.seg2_dir_y = 16'sd16384;
        s.seg2_length = 31'h7FFF_FFFF;
        send_segments(s);
        s.seg2_start_x = 32'h8000_0000; s.seg2_dir_x = -16'sd16384;
        s.seg1_start_x = 32'h8000_0000; s.seg1_dir_x = -16'sd16384;
        send_segments(s);
        // field extremes
        send_segments('0);
        send_segments('1);
        s = '1;
        s.seg1_dir_x = 16'h8000; s.seg1_dir_y = 16'h7FFF;
        s.seg2_dir_x = 16'h7FFF; s.seg2_dir_y = 16'h8000;
        send_segments(s);
        for (int i = 0; i < 10; i++)
            send_segments(noise_pair());
        release_start();
    endtask

    // Mostly well-formed crossings, some noise; a burst runs without gaps.
    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            gaps_on = !(i >= count / 3 && i < count / 3 + 120);
            if ($urandom_range(99) < 70)
                send_segments(crossing_pair());
            else
                send_segments(noise_pair());
        end
        gaps_on = 1'b1;
        release_start();
    endtask

    // Compare each done strobe against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                result_t exp_r;
                exp_r = expected_q.pop_front();
                if (result.hit !== exp_r.hit || result.cross_x !== exp_r.cross_x
                    || result.cross_y !== exp_r.cross_y)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp hit=%0d x=%0d y=%0d got hit=%0d x=%0d y=%0d",
                                 exp_r.hit, exp_r.cross_x, exp_r.cross_y,
                                 result.hit, result.cross_x, result.cross_y);
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction moving either way.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(740);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
